// ===== hdl/afc_pkg.sv =====
// Shared types and constants for the AABB frustum culling block.
// Used by aabb_frustum_cull; depends on nothing else.
`default_nettype none

package afc_pkg;

	// Number of plane registers on the configuration port.
	localparam int NUM_PLANE_REGS = 6;
	localparam int REG_IDX_W      = 3;
	localparam int PADDR_W        = 6;
	localparam int PDATA_W        = 64;

	localparam int FIELD_W    = 16;
	localparam int AXES       = 3;
	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 16;

	// Widths of the exact fixed-point terms.
	localparam int ABS_N_W  = 17;
	localparam int PROD_C_W = 32;
	localparam int PROD_S_W = 33;
	localparam int SUM_C_W  = 34;
	localparam int SUM_S_W  = 36;
	localparam int ACC_W    = 38;
	localparam int D_SHIFT  = 15;

	typedef logic signed [FIELD_W-1:0] fix16_t;

	// One plane register, normal x in the lowest bits.
	typedef struct packed {
		fix16_t d;
		fix16_t nz;
		fix16_t ny;
		fix16_t nx;
	} plane_t;

	// Input payload as packed in s_tdata, index in the lowest bits.
	typedef struct packed {
		fix16_t      size_z;
		fix16_t      size_y;
		fix16_t      size_x;
		fix16_t      center_z;
		fix16_t      center_y;
		fix16_t      center_x;
		logic [15:0] instance_index;
	} in_item_t;

endpackage

`default_nettype wire

// ===== hdl/aabb_frustum_cull.sv =====
// Top level of the AABB frustum culling block: stream in, stream out, APB planes.
// Depends on afc_pkg.
//
// Usage: each request on the s_ channel carries one instance (index, center, full
// size). The box is tested against the first PLANE_COUNT planes (planes beyond
// the six registers never cull). A box that passes every plane leaves as one
// request on the m_ channel holding its index; a culled box leaves nothing.
// Planes are written over APB at byte address 8*i, 64 bits each, and may only
// be changed while no box is in flight.
// The path from the accepting edge to m_tvalid runs through four register stages:
// stage 1 holds the 16x16 products, stage 2 the per-plane partial sums, stage 3
// the per-plane sign test and stage 4 the output register.
// Throughput is one box per cycle; each stage holds one box and moves on
// whenever the stage after it is free, so bubbles are squeezed out when the
// receiver stalls and s_tready drops only once all four stages are full.
// Reset clears all valid bits and all plane registers (zero planes never cull).
`default_nettype none

module aabb_frustum_cull #(
	parameter int PLANE_COUNT = 6
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// s_tdata: instance_index, center_x, center_y, center_z, size_x, size_y, size_z
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [afc_pkg::IN_DATA_W-1:0]   s_tdata,
	// m_tdata: visible_index
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [afc_pkg::OUT_DATA_W-1:0]       m_tdata,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [afc_pkg::PADDR_W-1:0]     paddr,
	input  wire logic [afc_pkg::PDATA_W-1:0]     pwdata,
	output logic [afc_pkg::PDATA_W-1:0]          prdata,
	output logic                                 pready
);
	import afc_pkg::*;

	localparam int LANES = (PLANE_COUNT < NUM_PLANE_REGS) ? PLANE_COUNT : NUM_PLANE_REGS;

	// Configuration registers.
	plane_t               plane_q [NUM_PLANE_REGS];
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 reg_hit;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
	assign reg_hit = (int'(reg_idx) < NUM_PLANE_REGS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANE_REGS; i++) plane_q[i] <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			plane_q[reg_idx] <= plane_t'(pwdata);
		end
	end

	always_comb begin
		prdata = '0;
		for (int i = 0; i < NUM_PLANE_REGS; i++) begin
			if (int'(reg_idx) == i) prdata = PDATA_W'(plane_q[i]);
		end
	end

	// Pipeline control: each stage advances when it is empty or its successor moves.
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4    = !valid_s4 || m_tready;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign s_tready = en_s1;

	in_item_t in_item;
	assign in_item = in_item_t'(s_tdata);

	fix16_t center [AXES];
	fix16_t size   [AXES];
	assign center[0] = in_item.center_x;
	assign center[1] = in_item.center_y;
	assign center[2] = in_item.center_z;
	assign size[0]   = in_item.size_x;
	assign size[1]   = in_item.size_y;
	assign size[2]   = in_item.size_z;

	logic [15:0] index_s1, index_s2, index_s3, index_s4;
	logic [LANES-1:0] pass_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= s_tvalid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3 && (&pass_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) index_s1 <= in_item.instance_index;
		if (en_s2) index_s2 <= index_s1;
		if (en_s3) index_s3 <= index_s2;
		if (en_s4) index_s4 <= index_s3;
	end

	for (genvar p = 0; p < LANES; p++) begin : g_plane
		fix16_t                      nrm [AXES];
		logic signed [ABS_N_W-1:0]   nabs [AXES];
		logic signed [PROD_C_W-1:0]  prod_c_s1 [AXES];
		logic signed [PROD_S_W-1:0]  prod_s_s1 [AXES];
		logic signed [SUM_C_W-1:0]   sum_c_s2;
		logic signed [SUM_S_W-1:0]   sum_s_s2;
		logic signed [SUM_S_W-1:0]   d_term;
		logic signed [ACC_W-1:0]     acc;

		assign nrm[0] = plane_q[p].nx;
		assign nrm[1] = plane_q[p].ny;
		assign nrm[2] = plane_q[p].nz;

		for (genvar k = 0; k < AXES; k++) begin : g_axis
			logic signed [ABS_N_W-1:0] n_ext;
			assign n_ext   = ABS_N_W'(nrm[k]);
			// The most negative normal becomes +32768, which the extra bit holds.
			assign nabs[k] = n_ext[ABS_N_W-1] ? -n_ext : n_ext;

			always_ff @(posedge clk) begin
				if (en_s1) begin
					prod_c_s1[k] <= PROD_C_W'(nrm[k]) * PROD_C_W'(center[k]);
					prod_s_s1[k] <= PROD_S_W'(nabs[k]) * PROD_S_W'(size[k]);
				end
			end
		end

		assign d_term = SUM_S_W'(plane_q[p].d) <<< D_SHIFT;

		always_ff @(posedge clk) begin
			if (en_s2) begin
				sum_c_s2 <= SUM_C_W'(prod_c_s1[0]) + SUM_C_W'(prod_c_s1[1])
					+ SUM_C_W'(prod_c_s1[2]);
				sum_s_s2 <= SUM_S_W'(prod_s_s1[0]) + SUM_S_W'(prod_s_s1[1])
					+ SUM_S_W'(prod_s_s1[2]) + d_term;
			end
		end

		// The center products count twice, which absorbs the halving of the size.
		assign acc = (ACC_W'(sum_c_s2) <<< 1) + ACC_W'(sum_s_s2);

		always_ff @(posedge clk) begin
			if (en_s3) pass_s3[p] <= !acc[ACC_W-1];
		end
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = index_s4;

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && valid_s4 && !m_tready) |-> !s_tready)
		else $error("input accepted while the whole pipeline is stalled");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !en_s1) |=> (valid_s1 && $stable(index_s1)))
		else $error("stage 1 lost or changed a stalled box");

	a_advance_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && en_s3) |=> valid_s3)
		else $error("box lost between stage 2 and stage 3");

	a_cull: assert property (@(posedge clk) disable iff (!arst_n)
		(en_s4 && valid_s3 && !(&pass_s3)) |=> !valid_s4)
		else $error("culled box reached the output");

endmodule

`default_nettype wire

// ===== dv/tb_aabb_frustum_cull.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for aabb_frustum_cull: streams boxes through the block and checks
// every emitted index against a directed verdict or an exact fixed-point plane test.
// Depends on afc_pkg and aabb_frustum_cull.

module tb_aabb_frustum_cull;
	import afc_pkg::*;

	localparam int PLANE_COUNT     = 6;
	localparam int MAX_PLANES      = 8;
	localparam int REG_STRIDE      = 8;
	localparam int DRAIN_CYCLES    = 12;
	localparam int STALL_LIMIT     = 4000;
	localparam int RANDOM_BOXES    = 700;
	localparam int BOXES_PER_PHASE = 100;
	localparam int MAX_PHASES      = 40;

	typedef enum logic [1:0] {PS_RESET, PS_EDGE, PS_ONES, PS_MAX} plane_set_e;
	typedef enum logic [1:0] {EXP_PRED, EXP_SHOWN, EXP_CULLED} verdict_e;

	typedef struct packed {
		plane_set_e  set;
		verdict_e    want;
		logic [15:0] idx;
		fix16_t      cx;
		fix16_t      cy;
		fix16_t      cz;
		fix16_t      sx;
		fix16_t      sy;
		fix16_t      sz;
	} box_row_t;

	// Plane set, expected verdict, index, center x/y/z, size x/y/z.
	localparam box_row_t DIR_ROWS [18] = '{
		'{PS_RESET, EXP_SHOWN,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
		'{PS_RESET, EXP_SHOWN,  16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
		'{PS_RESET, EXP_SHOWN,  16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000},
		'{PS_RESET, EXP_SHOWN,  16'h1234, 16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 16'hFFFF, 16'h0001},
		'{PS_EDGE,  EXP_PRED,   16'h0010, 16'hC000, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h0000},
		'{PS_EDGE,  EXP_PRED,   16'h0011, 16'hC000, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h8000, 16'h0000},
		'{PS_EDGE,  EXP_PRED,   16'h0012, 16'h0100, 16'h7FFF, 16'h0000, 16'h0200, 16'h7FFF, 16'h0000},
		'{PS_EDGE,  EXP_PRED,   16'h0013, 16'h0100, 16'h7FFF, 16'h0000, 16'h01FF, 16'h7FFF, 16'h0000},
		'{PS_EDGE,  EXP_PRED,   16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000},
		'{PS_EDGE,  EXP_PRED,   16'h5A5A, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
		'{PS_EDGE,  EXP_PRED,   16'hA5A5, 16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 16'h7FFF},
		'{PS_ONES,  EXP_CULLED, 16'h0020, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
		'{PS_ONES,  EXP_PRED,   16'h0021, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000},
		'{PS_ONES,  EXP_PRED,   16'h0022, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF},
		'{PS_MAX,   EXP_PRED,   16'h0030, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000},
		'{PS_MAX,   EXP_SHOWN,  16'h0031, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
		'{PS_MAX,   EXP_PRED,   16'h0032, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
		'{PS_MAX,   EXP_PRED,   16'h0033, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	// s_tdata: instance_index, center_x, center_y, center_z, size_x, size_y, size_z
	logic [IN_DATA_W-1:0]   s_tdata;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// m_tdata: visible_index
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [PADDR_W-1:0]     paddr;
	logic [PDATA_W-1:0]     pwdata;
	logic [PDATA_W-1:0]     prdata;
	logic                   pready;

	plane_t      plane_q [MAX_PLANES];
	logic [15:0] visible_q [$];
	logic [15:0] oldest_index;
	int          errors = 0;
	int          sent = 0;
	int          idle_cycles = 0;
	int          rx_hold = 0;
	bit          tx_gaps = 1'b0;
	bit          rx_stalls = 1'b0;

	aabb_frustum_cull #(
		.PLANE_COUNT(PLANE_COUNT)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Exact plane test at scale 2^23; the factor 2 and the shift absorb the halved size.
	function automatic bit box_in_frustum(in_item_t b);
		longint ctr [3];
		longint ext [3];
		longint nrm [3];
		longint acc;
		plane_t pl;
		ctr[0] = b.center_x;
		ctr[1] = b.center_y;
		ctr[2] = b.center_z;
		ext[0] = b.size_x;
		ext[1] = b.size_y;
		ext[2] = b.size_z;
		for (int p = 0; p < PLANE_COUNT && p < MAX_PLANES; p++) begin
			pl = plane_q[p];
			nrm[0] = pl.nx;
			nrm[1] = pl.ny;
			nrm[2] = pl.nz;
			acc = longint'(pl.d) * 32768;
			for (int k = 0; k < AXES; k++)
				acc += 2 * nrm[k] * ctr[k] + ((nrm[k] < 0) ? -nrm[k] : nrm[k]) * ext[k];
			if (acc < 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic plane_t edge_plane(plane_set_e ps, int idx);
		// Indexes past the register file get a plane that would cull everything.
		if (idx >= NUM_PLANE_REGS)
			return 64'h8000_0000_0000_0000;
		case (ps)
			PS_ONES: return '1;
			PS_MAX:  return 64'h7FFF_7FFF_7FFF_7FFF;
			default: begin
				case (idx)
					0:       return 64'h0000_0000_0000_8000;
					1:       return 64'h8000_0000_4000_0000;
					2:       return 64'h7FFF_7FFF_7FFF_7FFF;
					4:       return 64'h7FFF_C000_0000_0000;
					default: return '0;
				endcase
			end
		endcase
	endfunction

	function automatic plane_t random_plane(int raw_pct);
		plane_t pl;
		int r;
		r = $urandom_range(0, 99);
		if (r < raw_pct)
			pl = {$urandom, $urandom};
		else if (r < raw_pct + 10)
			pl = '0;
		else begin
			pl.nx = fix16_t'($urandom);
			pl.ny = fix16_t'($urandom);
			pl.nz = fix16_t'($urandom);
			pl.d  = fix16_t'($urandom_range(16'h0400, 16'h7FFF));
		end
		return pl;
	endfunction

	function automatic fix16_t near_coord();
		return fix16_t'($urandom_range(0, 16'h1000)) - 16'sh0800;
	endfunction

	function automatic fix16_t near_size();
		if ($urandom_range(0, 9) == 0)
			return -fix16_t'($urandom_range(0, 16'h0400));
		return fix16_t'($urandom_range(0, 16'h1000));
	endfunction

	function automatic in_item_t random_box();
		in_item_t b;
		b.instance_index = 16'($urandom);
		if ($urandom_range(0, 3) == 0)
			b[IN_DATA_W-1:FIELD_W] = {$urandom, $urandom, $urandom};
		else begin
			b.center_x = near_coord();
			b.center_y = near_coord();
			b.center_z = near_coord();
			b.size_x   = near_size();
			b.size_y   = near_size();
			b.size_z   = near_size();
		end
		return b;
	endfunction

	task automatic apb_write(int idx, plane_t val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(idx * REG_STRIDE);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx < NUM_PLANE_REGS)
			plane_q[idx] = val;
	endtask

	// Culled boxes leave no trace, so wait out the pipeline after the last index.
	task automatic drain();
		while (visible_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_box(in_item_t box, verdict_e want);
		int gap;
		gap = tx_gaps ? gap_len() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= box;
		do
			@(posedge clk);
		while (!s_tready);
		if (want == EXP_SHOWN || (want == EXP_PRED && box_in_frustum(box)))
			visible_q.push_back(box.instance_index);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (visible_q.size() == 0) begin
				$display("%0t: visible_index expected none, got %h", $time, m_tdata);
				errors++;
			end else begin
				oldest_index = visible_q.pop_front();
				if (m_tdata !== oldest_index) begin
					$display("%0t: visible_index expected %h, got %h", $time, oldest_index,
						m_tdata);
					errors++;
				end
			end
		end
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold  <= rx_hold - 1;
		end else begin
			m_tready <= 1'b1;
			if (rx_stalls)
				rx_hold <= gap_len();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		plane_set_e loaded;
		in_item_t   box;
		int         raw_pct;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		arst_n   = 1'b0;
		foreach (plane_q[i])
			plane_q[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
		loaded    = PS_RESET;
		foreach (DIR_ROWS[r]) begin
			if (DIR_ROWS[r].set != loaded) begin
				s_tvalid <= 1'b0;
				drain();
				loaded = DIR_ROWS[r].set;
				for (int i = 0; i < MAX_PLANES; i++)
					apb_write(i, edge_plane(loaded, i));
			end
			box.instance_index = DIR_ROWS[r].idx;
			box.center_x       = DIR_ROWS[r].cx;
			box.center_y       = DIR_ROWS[r].cy;
			box.center_z       = DIR_ROWS[r].cz;
			box.size_x         = DIR_ROWS[r].sx;
			box.size_y         = DIR_ROWS[r].sy;
			box.size_z         = DIR_ROWS[r].sz;
			send_box(box, DIR_ROWS[r].want);
		end

		// Each phase loads a new plane set with some raw bit patterns, all raw when phase % 5 is 1.
		for (int phase = 0; sent < RANDOM_BOXES && phase < MAX_PHASES; phase++) begin
			s_tvalid <= 1'b0;
			drain();
			tx_gaps   = ($urandom_range(0, 3) != 0);
			rx_stalls = ($urandom_range(0, 3) != 0);
			raw_pct   = (phase % 5 == 1) ? 100 : $urandom_range(0, 25);
			for (int i = 0; i < MAX_PLANES; i++)
				if (i < NUM_PLANE_REGS || $urandom_range(0, 3) == 0)
					apb_write(i, random_plane(raw_pct));
			for (int n = 0; n < BOXES_PER_PHASE; n++) begin
				send_box(random_box(), EXP_PRED);
				sent++;
			end
		end
		s_tvalid <= 1'b0;
		drain();

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
